[design/shared_array_dual_stack_assert.svh]
// assertion macros shared by the dual stack rtl
// depends on nothing; the assertion bodies drop out when SYNTHESIS is defined
`ifndef SHARED_ARRAY_DUAL_STACK_ASSERT_SVH
`define SHARED_ARRAY_DUAL_STACK_ASSERT_SVH

`ifndef SYNTHESIS

// condition must hold at every edge out of reset
`define SADS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("dual stack check failed");

// antecedent implies consequent in the same cycle
`define SADS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dual stack check failed");

// antecedent implies consequent in the next cycle
`define SADS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dual stack check failed");

`else

`define SADS_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define SADS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SADS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[design/sads_pkg.sv]
// types, codes and sizes for the dual stack sharing one memory
// no dependencies; used by every module of the block
package sads_pkg;

	// memory size and derived widths
	localparam int DEPTH  = 32;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	// request codes
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;
	localparam logic SEL_LOW  = 1'b0;
	localparam logic SEL_HIGH = 1'b1;

	// response status codes
	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// controller states
	typedef enum logic {
		CTL_IDLE,
		CTL_RESP
	} ctl_state_t;

	// request word
	typedef struct packed {
		logic               cmd;
		logic               stack_select;
		logic signed [31:0] push_value;
	} req_word_t;

	// response word
	typedef struct packed {
		status_t            status;
		logic signed [31:0] pop_value;
	} rsp_word_t;

	// controller to datapath commands
	typedef struct packed {
		logic take;
	} dp_cmd_t;

endpackage

[design/sads_ctrl.sv]
// handshake controller for the dual stack
// depends on sads_pkg; drives the datapath through a dp_cmd_t
module sads_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output sads_pkg::dp_cmd_t cmd
);

	sads_pkg::ctl_state_t state_q;
	sads_pkg::ctl_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sads_pkg::CTL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake outputs
	always_comb begin
		state_d   = state_q;
		rsp_valid = 1'b0;
		req_ready = 1'b0;
		case (state_q)
			sads_pkg::CTL_IDLE: begin
				req_ready = 1'b1;
			end
			sads_pkg::CTL_RESP: begin
				rsp_valid = 1'b1;
				// a new word may enter in the cycle the old response leaves
				req_ready = rsp_ready;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
		cmd.take = req_valid && req_ready;
		if (cmd.take) begin
			state_d = sads_pkg::CTL_RESP;
		end else if (rsp_valid && rsp_ready) begin
			state_d = sads_pkg::CTL_IDLE;
		end
	end

endmodule

[design/sads_dp.sv]
// datapath of the dual stack: pointers, shared memory and response register
// depends on sads_pkg and shared_array_dual_stack_assert.svh
`include "shared_array_dual_stack_assert.svh"

module sads_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  sads_pkg::dp_cmd_t   cmd,
	input  sads_pkg::req_word_t req,
	output sads_pkg::rsp_word_t rsp
);

	logic signed [31:0] mem [sads_pkg::DEPTH];

	logic [sads_pkg::CNT_W-1:0]  low_cnt_q;
	logic [sads_pkg::CNT_W-1:0]  high_cnt_q;
	logic [sads_pkg::CNT_W-1:0]  low_cnt_d;
	logic [sads_pkg::CNT_W-1:0]  high_cnt_d;
	logic [sads_pkg::CNT_W-1:0]  low_dec;
	logic [sads_pkg::CNT_W-1:0]  high_dec;
	logic [sads_pkg::CNT_W:0]    cnt_sum;
	logic [sads_pkg::ADDR_W-1:0] addr;
	logic                        full;
	logic                        is_pop;
	logic                        is_high;
	logic                        mem_we;
	logic                        mem_re;
	sads_pkg::status_t           status_d;
	sads_pkg::status_t           status_q;
	logic                        pop_ok_q;
	logic signed [31:0]          rdata_q;

	localparam logic [sads_pkg::ADDR_W-1:0] LAST_ADDR = sads_pkg::ADDR_W'(sads_pkg::DEPTH - 1);

	// occupancy
	assign cnt_sum  = {1'b0, low_cnt_q} + {1'b0, high_cnt_q};
	assign full     = (cnt_sum == (sads_pkg::CNT_W + 1)'(sads_pkg::DEPTH));
	assign low_dec  = low_cnt_q - 1'b1;
	assign high_dec = high_cnt_q - 1'b1;
	assign is_pop   = (req.cmd == sads_pkg::CMD_POP);
	assign is_high  = (req.stack_select == sads_pkg::SEL_HIGH);

	// request decode: status, memory access and new pointers
	always_comb begin
		status_d   = sads_pkg::ST_DONE;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		low_cnt_d  = low_cnt_q;
		high_cnt_d = high_cnt_q;
		addr       = low_cnt_q[sads_pkg::ADDR_W-1:0];
		if (!is_pop) begin
			if (full) begin
				status_d = sads_pkg::ST_FULL;
			end else if (!is_high) begin
				mem_we    = cmd.take;
				low_cnt_d = low_cnt_q + 1'b1;
			end else begin
				addr       = LAST_ADDR - high_cnt_q[sads_pkg::ADDR_W-1:0];
				mem_we     = cmd.take;
				high_cnt_d = high_cnt_q + 1'b1;
			end
		end else if (!is_high) begin
			addr = low_dec[sads_pkg::ADDR_W-1:0];
			if (low_cnt_q == '0) begin
				status_d = sads_pkg::ST_EMPTY;
			end else begin
				mem_re    = cmd.take;
				low_cnt_d = low_dec;
			end
		end else begin
			addr = LAST_ADDR - high_dec[sads_pkg::ADDR_W-1:0];
			if (high_cnt_q == '0) begin
				status_d = sads_pkg::ST_EMPTY;
			end else begin
				mem_re     = cmd.take;
				high_cnt_d = high_dec;
			end
		end
	end

	// stack pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_cnt_q  <= '0;
			high_cnt_q <= '0;
		end else if (cmd.take) begin
			low_cnt_q  <= low_cnt_d;
			high_cnt_q <= high_cnt_d;
		end
	end

	// shared memory, one port with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr] <= req.push_value;
		end
		if (mem_re) begin
			rdata_q <= mem[addr];
		end
	end

	// response register
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			status_q <= status_d;
			pop_ok_q <= is_pop && (status_d == sads_pkg::ST_DONE);
		end
	end

	assign rsp.status    = status_q;
	assign rsp.pop_value = pop_ok_q ? rdata_q : 32'sd0;

	// checks
	`SADS_ASSERT_ALWAYS(a_cnt_bound, clk, arst_n, cnt_sum <= (sads_pkg::CNT_W + 1)'(sads_pkg::DEPTH))
	`SADS_ASSERT_NEXT(a_refused_holds, clk, arst_n, cmd.take && (status_d != sads_pkg::ST_DONE), $stable(low_cnt_q) && $stable(high_cnt_q))
	`SADS_ASSERT_NEXT(a_push_grows, clk, arst_n, cmd.take && !is_pop && (status_d == sads_pkg::ST_DONE), cnt_sum == $past(cnt_sum) + 1'b1)
	`SADS_ASSERT_IMPLY(a_single_access, clk, arst_n, mem_we, !mem_re)

endmodule

[design/shared_array_dual_stack.sv]
// Two LIFO stacks in one shared memory of sads_pkg::DEPTH words: the low stack grows up from
// entry 0, the high stack down from the last entry. Each request word (push or pop on either
// stack) gives exactly one response word with a status and, for a successful pop, the value.
// The response is registered and shows in the cycle after acceptance, via the registered read
// port of the shared memory; a new request is taken in the same cycle the previous response
// is taken, so with rsp_ready held high the block sustains one request per cycle. Pointers
// clear at reset; the memory needs no clearing pass since only written entries are read.
// depends on sads_pkg, sads_ctrl and sads_dp
module shared_array_dual_stack (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  sads_pkg::req_word_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output sads_pkg::rsp_word_t rsp
);

	sads_pkg::dp_cmd_t cmd;

	// handshake controller
	sads_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	// pointers, memory and response register
	sads_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

[tb/tb_shared_array_dual_stack.sv]
// testbench for shared_array_dual_stack: directed and random push/pop words on both stacks,
// checked against a behavioural dual stack model kept in step with accepted requests
// depends on sads_pkg and the shared_array_dual_stack rtl
`timescale 1ns / 1ps

module tb_shared_array_dual_stack;
	import sads_pkg::*;

	localparam int N_TARGET  = 1400;
	localparam int PHASE_A   = 470;
	localparam int PHASE_B   = 940;
	localparam int HOLD_AT   = 1150;
	localparam int HOLD_LEN  = 80;
	localparam int DRAIN_CYC = 6;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	req_word_t req = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_word_t rsp;

	// stimulus and scoreboard storage
	req_word_t   pending_req[$];
	rsp_word_t   expected_rsp[$];
	int          n_items = 0;
	int          taken_cnt = 0;
	int          err_cnt = 0;
	bit          req_fired = 1'b0;
	int          hold_left = 0;
	bit          hold_done = 1'b0;

	// behavioural copy of the shared memory and both stack depths
	logic [31:0] stack_mem [DEPTH];
	int          low_cnt = 0;
	int          high_cnt = 0;

	shared_array_dual_stack uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #1 clk = ~clk;

	// apply one request word to the model and return the response it should give
	function automatic rsp_word_t predict_stack_rsp(input req_word_t w);
		rsp_word_t r;
		r.status    = ST_DONE;
		r.pop_value = '0;
		if (w.cmd == CMD_PUSH) begin
			if (low_cnt + high_cnt >= DEPTH) begin
				r.status = ST_FULL;
			end else if (w.stack_select == SEL_LOW) begin
				stack_mem[low_cnt] = w.push_value;
				low_cnt++;
			end else begin
				stack_mem[DEPTH - 1 - high_cnt] = w.push_value;
				high_cnt++;
			end
		end else if (w.stack_select == SEL_LOW) begin
			if (low_cnt == 0) begin
				r.status = ST_EMPTY;
			end else begin
				low_cnt--;
				r.pop_value = stack_mem[low_cnt];
			end
		end else begin
			if (high_cnt == 0) begin
				r.status = ST_EMPTY;
			end else begin
				high_cnt--;
				r.pop_value = stack_mem[DEPTH - 1 - high_cnt];
			end
		end
		return r;
	endfunction

	// idle percentage per side: sender 27 / receiver 45, then swapped, then none
	function automatic int idle_pct(input bit rx_side);
		if (taken_cnt < PHASE_A)
			return rx_side ? 45 : 27;
		else if (taken_cnt < PHASE_B)
			return rx_side ? 27 : 45;
		return 0;
	endfunction

	task automatic add_req(input logic c, input logic s, input logic [31:0] v);
		req_word_t w;
		w.cmd          = c;
		w.stack_select = s;
		w.push_value   = v;
		pending_req.push_back(w);
	endtask

	// driver: holds a word until accepted, otherwise offers the next one or idles
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_valid || req_fired) begin
				if (pending_req.size() > 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
					req       <= pending_req.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls plus one long hold-off to back the block up
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else if (!hold_done && taken_cnt >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_LEN;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= ($urandom_range(99) >= idle_pct(1'b1));
			end
		end
	end

	// monitor: check taken responses first, then record the prediction for a taken request
	always @(posedge clk) begin
		rsp_word_t exp_w;
		if (!arst_n) begin
			req_fired = 1'b0;
		end else begin
			req_fired = req_valid && req_ready;
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp.size() == 0) begin
					$display("%0t: response with none expected, actual status %0d value %h",
						$time, rsp.status, rsp.pop_value);
					err_cnt++;
				end else begin
					exp_w = expected_rsp.pop_front();
					if (rsp.status !== exp_w.status) begin
						$display("%0t: status mismatch, expected %0d actual %0d",
							$time, exp_w.status, rsp.status);
						err_cnt++;
					end
					if (rsp.pop_value !== exp_w.pop_value) begin
						$display("%0t: pop_value mismatch, expected %h actual %h",
							$time, exp_w.pop_value, rsp.pop_value);
						err_cnt++;
					end
				end
			end
			if (req_fired) begin
				expected_rsp.push_back(predict_stack_rsp(req));
				taken_cnt++;
			end
		end
	end

	// run limit
	initial begin
		#200000;
		$display("shared_array_dual_stack test failed");
		$finish;
	end

	// stimulus and end of run
	initial begin
		int seg_len;
		int push_pct;
		int high_pct;

		// directed: empty pops, extreme words on both stacks, unwind in lifo order
		add_req(CMD_POP,  SEL_LOW,  32'h0000_0000);
		add_req(CMD_POP,  SEL_HIGH, 32'hffff_ffff);
		add_req(CMD_PUSH, SEL_LOW,  32'h8000_0000);
		add_req(CMD_PUSH, SEL_HIGH, 32'h7fff_ffff);
		add_req(CMD_PUSH, SEL_LOW,  32'h0000_0000);
		add_req(CMD_PUSH, SEL_HIGH, 32'hffff_ffff);
		add_req(CMD_PUSH, SEL_LOW,  32'h5555_5555);
		add_req(CMD_PUSH, SEL_HIGH, 32'haaaa_aaaa);
		add_req(CMD_POP,  SEL_HIGH, 32'h1234_5678);
		add_req(CMD_POP,  SEL_LOW,  32'h0000_0000);
		add_req(CMD_POP,  SEL_HIGH, 32'hffff_ffff);
		add_req(CMD_POP,  SEL_LOW,  32'h0000_0000);
		add_req(CMD_POP,  SEL_HIGH, 32'h0000_0000);
		add_req(CMD_POP,  SEL_LOW,  32'h0000_0000);
		add_req(CMD_POP,  SEL_LOW,  32'h0000_0000);
		add_req(CMD_POP,  SEL_HIGH, 32'h0000_0000);

		// random: segments with a push/pop bias and a stack bias so both stacks
		// fill to the meeting point and drain back to empty
		while (pending_req.size() < N_TARGET) begin
			seg_len = $urandom_range(60, 20);
			case ($urandom_range(2))
				0: push_pct = 85;
				1: push_pct = 50;
				default: push_pct = 15;
			endcase
			case ($urandom_range(2))
				0: high_pct = 10;
				1: high_pct = 50;
				default: high_pct = 90;
			endcase
			repeat (seg_len) begin
				add_req(($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP,
					($urandom_range(99) < high_pct) ? SEL_HIGH : SEL_LOW, $urandom);
			end
		end
		n_items = pending_req.size();

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		wait (taken_cnt == n_items);
		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		if (err_cnt == 0)
			$display("shared_array_dual_stack test passed");
		else
			$display("shared_array_dual_stack test failed");
		$finish;
	end

endmodule
